// ===== src/gne_pkg.sv =====
package gne_pkg;

  // Grid limits
  localparam int MAX_COLS  = 64;
  localparam int MAX_ROWS  = 64;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int MAP_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  // Field widths
  localparam int DIM_W   = 7;
  localparam int ID_W    = 12;
  localparam int OCC_W   = 2;
  localparam int PITCH_W = 10;
  localparam int COST_W  = 19;
  localparam int FRAC_W  = 8;
  localparam int AREA_W  = 2 * DIM_W;

  // Diagonal cost: isqrt of 2 * (pitch << FRAC_W)^2 = pitch^2 << (2*FRAC_W + 1)
  localparam int SQ_SHIFT   = 2 * FRAC_W + 1;
  localparam int SQ_W       = 2 * PITCH_W + SQ_SHIFT;
  localparam int SQ_STEPS   = (SQ_W + 1) / 2;
  localparam int DIV_STEPS  = ID_W;
  localparam int ARITH_DONE = SQ_STEPS + 1;
  localparam int ACNT_W     = $clog2(ARITH_DONE + 1);

  // Neighbor scan
  localparam int NB_W     = 4;
  localparam int NB_COUNT8 = 8;
  localparam int NB_COUNT4 = 4;

  // Configuration port
  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_GRID_COLS        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ALLOW_DIAGONAL   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IGNORE_OBSTACLES = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CELL_PITCH       = 3'd4;

  localparam logic [DIM_W-1:0]   RST_GRID_COLS  = 7'd64;
  localparam logic [DIM_W-1:0]   RST_GRID_ROWS  = 7'd64;
  localparam logic [PITCH_W-1:0] RST_CELL_PITCH = 10'd10;

  // Item codes
  localparam logic             FUNC_WRITE   = 1'b0;
  localparam logic             FUNC_QUERY   = 1'b1;
  localparam logic [OCC_W-1:0] OCC_FREE     = 2'd0;
  localparam logic [OCC_W-1:0] OCC_OCCUPIED = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_CALC,
    ST_SCAN,
    ST_TEST,
    ST_FLUSH
  } gne_state_e;

  typedef struct packed {
    logic [DIM_W-1:0]   grid_cols;
    logic [DIM_W-1:0]   grid_rows;
    logic               allow_diagonal;
    logic               ignore_obstacles;
    logic [PITCH_W-1:0] cell_pitch;
  } gne_cfg_t;

  typedef struct packed {
    logic clr_step;
    logic load_in;
    logic wr_map;
    logic start;
    logic cand_clr;
    logic rd_cand;
    logic cand_next;
    logic take_cand;
    logic push;
    logic push_last;
  } gne_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic is_query;
    logic arith_done;
    logic map_blocked;
    logic cand_end;
    logic cand_ok;
    logic have_pend;
    logic out_free;
  } gne_sts_t;

  typedef struct packed {
    logic signed [1:0] dc;
    logic signed [1:0] dr;
  } gne_ofs_t;

  // Neighbor offsets in emit order.
  function automatic gne_ofs_t nb_offset(input logic [2:0] k, input logic diag);
    gne_ofs_t o;
    o = '0;
    if (diag) begin
      case (k)
        3'd0: o = '{dc: -2'sd1, dr: -2'sd1};
        3'd1: o = '{dc: -2'sd1, dr:  2'sd0};
        3'd2: o = '{dc: -2'sd1, dr:  2'sd1};
        3'd3: o = '{dc:  2'sd0, dr: -2'sd1};
        3'd4: o = '{dc:  2'sd0, dr:  2'sd1};
        3'd5: o = '{dc:  2'sd1, dr: -2'sd1};
        3'd6: o = '{dc:  2'sd1, dr:  2'sd0};
        3'd7: o = '{dc:  2'sd1, dr:  2'sd1};
        default: o = '0;
      endcase
    end else begin
      case (k[1:0])
        2'd0: o = '{dc:  2'sd0, dr:  2'sd1};
        2'd1: o = '{dc:  2'sd0, dr: -2'sd1};
        2'd2: o = '{dc:  2'sd1, dr:  2'sd0};
        2'd3: o = '{dc: -2'sd1, dr:  2'sd0};
        default: o = '0;
      endcase
    end
    return o;
  endfunction

  // Clamp a grid dimension to 1..max_v.
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > max_v) r = max_v;
    return r;
  endfunction

endpackage

// ===== src/gne_if.sv =====
interface gne_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [gne_pkg::ID_W-1:0]       cell_id;
  logic [gne_pkg::OCC_W-1:0]      occupancy;

  modport source (output valid, func, cell_id, occupancy, input ready);
  modport sink   (input valid, func, cell_id, occupancy, output ready);
endinterface

interface gne_out_if;
  logic                           valid;
  logic                           ready;
  logic [gne_pkg::ID_W-1:0]       neighbor_id;
  logic [gne_pkg::COL_W-1:0]      neighbor_col;
  logic [gne_pkg::ROW_W-1:0]      neighbor_row;
  logic [gne_pkg::COST_W-1:0]     edge_cost;
  logic                           last;

  modport source (output valid, neighbor_id, neighbor_col, neighbor_row, edge_cost, last,
                  input ready);
  modport sink   (input valid, neighbor_id, neighbor_col, neighbor_row, edge_cost, last,
                  output ready);
endinterface

// ===== src/gne_ram.sv =====
module gne_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/gne_arith.sv =====
// Iterative id / cols divider and pitch * sqrt(2) rounding square root.
module gne_arith (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gne_pkg::ID_W-1:0]      id_i,
  input  logic [gne_pkg::DIM_W-1:0]     cols_i,
  input  logic [gne_pkg::PITCH_W-1:0]   pitch_i,
  output logic                          done_o,
  output logic [gne_pkg::COL_W-1:0]     col_o,
  output logic [gne_pkg::ROW_W-1:0]     row_o,
  output logic [gne_pkg::COST_W-1:0]    diag_o
);

  localparam int DW = gne_pkg::DIM_W;
  localparam int IW = gne_pkg::ID_W;
  localparam int SW = gne_pkg::SQ_W;
  localparam int CW = gne_pkg::ACNT_W;

  logic [CW-1:0]   cnt_q, cnt_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [IW-1:0]   quo_q, quo_d;
  logic [SW-1:0]   v_q, v_d;
  logic [SW-1:0]   res_q, res_d;
  logic [SW-1:0]   bit_q, bit_d;
  logic [DW:0]     trial;
  logic [SW:0]     sum;
  logic [2*gne_pkg::PITCH_W-1:0] pitch_sq;

  always_comb begin
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    v_d      = v_q;
    res_d    = res_q;
    bit_d    = bit_q;
    trial    = {rem_q, quo_q[IW-1]};
    sum      = {1'b0, res_q} + {1'b0, bit_q};
    pitch_sq = pitch_i * pitch_i;

    if (start_i) begin
      cnt_d = '0;
      rem_d = '0;
      quo_d = id_i;
      v_d   = {pitch_sq, {gne_pkg::SQ_SHIFT{1'b0}}};
      res_d = '0;
      bit_d = SW'(1) << (2 * (gne_pkg::SQ_STEPS - 1));
    end else if (cnt_q != CW'(gne_pkg::ARITH_DONE)) begin
      cnt_d = cnt_q + CW'(1);
      // restoring division, one quotient bit per cycle
      if (cnt_q < CW'(gne_pkg::DIV_STEPS)) begin
        if (trial >= {1'b0, cols_i}) begin
          rem_d = DW'(trial - {1'b0, cols_i});
          quo_d = {quo_q[IW-2:0], 1'b1};
        end else begin
          rem_d = trial[DW-1:0];
          quo_d = {quo_q[IW-2:0], 1'b0};
        end
      end
      // digit-by-digit square root, then round to nearest
      if (cnt_q < CW'(gne_pkg::SQ_STEPS)) begin
        if ({1'b0, v_q} >= sum) begin
          v_d   = v_q - sum[SW-1:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else if (v_q > res_q) begin
        res_d = res_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CW'(gne_pkg::ARITH_DONE);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = (cnt_q == CW'(gne_pkg::ARITH_DONE));
  assign col_o  = rem_q[gne_pkg::COL_W-1:0];
  assign row_o  = quo_q[gne_pkg::ROW_W-1:0];
  assign diag_o = res_q[gne_pkg::COST_W-1:0];

endmodule

// ===== src/gne_ctrl.sv =====
module gne_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gne_pkg::gne_sts_t  sts_i,
  output gne_pkg::gne_cmd_t  cmd_o
);

  gne_pkg::gne_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gne_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      gne_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = gne_pkg::ST_IDLE;
      end
      gne_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = gne_pkg::ST_CHECK;
        end
      end
      gne_pkg::ST_CHECK: begin
        if (!sts_i.in_range) begin
          state_d = gne_pkg::ST_IDLE;
        end else if (!sts_i.is_query) begin
          cmd_o.wr_map = 1'b1;
          state_d      = gne_pkg::ST_IDLE;
        end else begin
          cmd_o.start = 1'b1;
          state_d     = gne_pkg::ST_CALC;
        end
      end
      gne_pkg::ST_CALC: begin
        if (sts_i.arith_done) begin
          if (sts_i.map_blocked) begin
            state_d = gne_pkg::ST_IDLE;
          end else begin
            cmd_o.cand_clr = 1'b1;
            state_d        = gne_pkg::ST_SCAN;
          end
        end
      end
      gne_pkg::ST_SCAN: begin
        if (sts_i.cand_end) begin
          state_d = gne_pkg::ST_FLUSH;
        end else begin
          cmd_o.cand_next = 1'b1;
          if (sts_i.cand_ok) begin
            cmd_o.rd_cand = 1'b1;
            state_d       = gne_pkg::ST_TEST;
          end
        end
      end
      gne_pkg::ST_TEST: begin
        if (sts_i.map_blocked) begin
          state_d = gne_pkg::ST_SCAN;
        end else if (!sts_i.have_pend) begin
          cmd_o.take_cand = 1'b1;
          state_d         = gne_pkg::ST_SCAN;
        end else if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.take_cand = 1'b1;
          state_d         = gne_pkg::ST_SCAN;
        end
      end
      gne_pkg::ST_FLUSH: begin
        if (!sts_i.have_pend) begin
          state_d = gne_pkg::ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = 1'b1;
          state_d         = gne_pkg::ST_IDLE;
        end
      end
      default: state_d = gne_pkg::ST_CLEAR;
    endcase
  end

endmodule

// ===== src/gne_dp.sv =====
module gne_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gne_pkg::gne_cfg_t             cfg_i,
  input  gne_pkg::gne_cmd_t             cmd_i,
  output gne_pkg::gne_sts_t             sts_o,
  input  logic                          in_func_i,
  input  logic [gne_pkg::ID_W-1:0]      in_cell_id_i,
  input  logic [gne_pkg::OCC_W-1:0]     in_occupancy_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [gne_pkg::ID_W-1:0]      out_neighbor_id_o,
  output logic [gne_pkg::COL_W-1:0]     out_neighbor_col_o,
  output logic [gne_pkg::ROW_W-1:0]     out_neighbor_row_o,
  output logic [gne_pkg::COST_W-1:0]    out_edge_cost_o,
  output logic                          out_last_o
);

  localparam int IW  = gne_pkg::ID_W;
  localparam int CLW = gne_pkg::COL_W;
  localparam int RW  = gne_pkg::ROW_W;
  localparam int DW  = gne_pkg::DIM_W;
  localparam int AW  = gne_pkg::MAP_AW;
  localparam int SCW = CLW + 2;
  localparam int SRW = RW + 2;

  // latched item
  logic                     func_q;
  logic [IW-1:0]            id_q;
  logic [gne_pkg::OCC_W-1:0] occ_q;

  // effective grid
  logic [DW-1:0]              cols_eff, rows_eff;
  logic [gne_pkg::AREA_W-1:0] area;

  // arith results
  logic                        arith_done;
  logic [CLW-1:0]              col;
  logic [RW-1:0]               row;
  logic [gne_pkg::COST_W-1:0]  diag_cost;
  logic [gne_pkg::COST_W-1:0]  straight_cost;

  // map
  logic [AW-1:0]              clr_cnt_q;
  logic                       map_we, map_re;
  logic [AW-1:0]              map_waddr, map_raddr;
  logic [gne_pkg::OCC_W-1:0]  map_wdata, map_rdata;

  // neighbor scan
  logic [gne_pkg::NB_W-1:0]   k_q;
  logic [gne_pkg::NB_W-1:0]   k_count;
  gne_pkg::gne_ofs_t          ofs;
  logic signed [SCW-1:0]      nc;
  logic signed [SRW-1:0]      nr;
  logic                       nc_ok, nr_ok, nb_diag;
  logic [RW+DW-1:0]           nid_w;
  logic [IW-1:0]              nid;

  logic [IW-1:0]  cand_id_q,  pend_id_q;
  logic [CLW-1:0] cand_col_q, pend_col_q;
  logic [RW-1:0]  cand_row_q, pend_row_q;
  logic           cand_diag_q, pend_diag_q;
  logic           have_pend_q;

  logic                       out_valid_q;
  logic [IW-1:0]              out_id_q;
  logic [CLW-1:0]             out_col_q;
  logic [RW-1:0]              out_row_q;
  logic [gne_pkg::COST_W-1:0] out_cost_q;
  logic                       out_last_q;

  assign cols_eff = gne_pkg::sat_dim(cfg_i.grid_cols, DW'(gne_pkg::MAX_COLS));
  assign rows_eff = gne_pkg::sat_dim(cfg_i.grid_rows, DW'(gne_pkg::MAX_ROWS));
  assign area     = cols_eff * rows_eff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= in_func_i;
      id_q   <= in_cell_id_i;
      occ_q  <= in_occupancy_i;
    end
  end

  gne_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .id_i    (id_q),
    .cols_i  (cols_eff),
    .pitch_i (cfg_i.cell_pitch),
    .done_o  (arith_done),
    .col_o   (col),
    .row_o   (row),
    .diag_o  (diag_cost)
  );

  assign straight_cost = gne_pkg::COST_W'({cfg_i.cell_pitch, {gne_pkg::FRAC_W{1'b0}}});

  // neighbor candidate for the current scan slot
  assign k_count = cfg_i.allow_diagonal ? gne_pkg::NB_W'(gne_pkg::NB_COUNT8)
                                        : gne_pkg::NB_W'(gne_pkg::NB_COUNT4);
  assign ofs     = gne_pkg::nb_offset(k_q[2:0], cfg_i.allow_diagonal);
  assign nc      = $signed({2'b00, col}) + $signed({{(SCW-2){ofs.dc[1]}}, ofs.dc});
  assign nr      = $signed({2'b00, row}) + $signed({{(SRW-2){ofs.dr[1]}}, ofs.dr});
  assign nc_ok   = !nc[SCW-1] && (DW'(nc[SCW-2:0]) < cols_eff);
  assign nr_ok   = !nr[SRW-1] && (DW'(nr[SRW-2:0]) < rows_eff);
  assign nb_diag = (ofs.dc != 2'sd0) && (ofs.dr != 2'sd0);
  assign nid_w   = (RW+DW)'(nr[RW-1:0]) * (RW+DW)'(cols_eff) + (RW+DW)'(nc[CLW-1:0]);
  assign nid     = nid_w[IW-1:0];

  // occupancy map, swept to free after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign map_we    = cmd_i.clr_step || cmd_i.wr_map;
  assign map_waddr = cmd_i.clr_step ? clr_cnt_q : AW'(id_q);
  assign map_wdata = cmd_i.clr_step ? gne_pkg::OCC_FREE : occ_q;
  assign map_re    = cmd_i.start || cmd_i.rd_cand;
  assign map_raddr = cmd_i.rd_cand ? AW'(nid) : AW'(id_q);

  gne_ram #(
    .WIDTH (gne_pkg::OCC_W),
    .DEPTH (gne_pkg::MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // scan index, candidate and pending edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      have_pend_q <= 1'b0;
    end else begin
      if (cmd_i.cand_clr) begin
        k_q <= '0;
      end else if (cmd_i.cand_next) begin
        k_q <= k_q + gne_pkg::NB_W'(1);
      end
      if (cmd_i.cand_clr || cmd_i.push_last) begin
        have_pend_q <= 1'b0;
      end else if (cmd_i.take_cand) begin
        have_pend_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_cand) begin
      cand_id_q   <= nid;
      cand_col_q  <= nc[CLW-1:0];
      cand_row_q  <= nr[RW-1:0];
      cand_diag_q <= nb_diag;
    end
    if (cmd_i.take_cand) begin
      pend_id_q   <= cand_id_q;
      pend_col_q  <= cand_col_q;
      pend_row_q  <= cand_row_q;
      pend_diag_q <= cand_diag_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_id_q   <= pend_id_q;
      out_col_q  <= pend_col_q;
      out_row_q  <= pend_row_q;
      out_cost_q <= pend_diag_q ? diag_cost : straight_cost;
      out_last_q <= cmd_i.push_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_neighbor_id_o  = out_id_q;
  assign out_neighbor_col_o = out_col_q;
  assign out_neighbor_row_o = out_row_q;
  assign out_edge_cost_o    = out_cost_q;
  assign out_last_o         = out_last_q;

  always_comb begin
    sts_o             = '0;
    sts_o.clr_last    = (clr_cnt_q == '1);
    sts_o.in_range    = ({{(gne_pkg::AREA_W-IW){1'b0}}, id_q} < area);
    sts_o.is_query    = (func_q == gne_pkg::FUNC_QUERY);
    sts_o.arith_done  = arith_done;
    sts_o.map_blocked = !cfg_i.ignore_obstacles && (map_rdata == gne_pkg::OCC_OCCUPIED);
    sts_o.cand_end    = (k_q == k_count);
    sts_o.cand_ok     = nc_ok && nr_ok;
    sts_o.have_pend   = have_pend_q;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

// ===== src/grid_neighbor_edge_generator.sv =====
// Grid neighbor edge generator.
// Input channel (in_i): one transfer carries func, cell_id and occupancy. A write
// (func 0) stores the occupancy of one cell; a query (func 1) produces the in-bounds
// 4- or 8-connected neighbors of that cell, each with its Q.8 edge cost, with last
// set on the final edge; occupied neighbors are skipped unless obstacles are ignored.
// Out-of-range ids, writes and queries with no usable neighbor produce no output.
// Output channel (out_o): one transfer per edge, held in an output register.
// Flow: one item at a time, in_i.ready high only while idle. A write or an
// out-of-range id is decoded and the block returns to idle. A query passes decode,
// the 12-step id/cols divider alongside the 19-step diagonal-cost root plus a
// rounding step, then reads the map for each in-bounds candidate and skips the rest,
// then closes and returns to idle. A query from an occupied cell (obstacles honored)
// returns to idle once the root is done.
// Config (APB, regs at 4*index): grid_cols, grid_rows, allow_diagonal,
// ignore_obstacles, cell_pitch; write only while the block is idle.
// Reset: the occupancy map is swept to free, one cell per cycle, with in_i.ready low;
// config writes are taken during the sweep.
// Stall: an edge waits in the output register; the next edge is held pending and
// the scan stops until out_o.ready frees the register.
module grid_neighbor_edge_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gne_in_if.sink                        in_i,
  gne_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gne_pkg::PADDR_W-1:0]   paddr,
  input  logic [gne_pkg::APB_DW-1:0]    pwdata,
  output logic [gne_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  gne_pkg::gne_cfg_t cfg_q;
  gne_pkg::gne_cmd_t cmd;
  gne_pkg::gne_sts_t sts;

  logic                              cfg_wr;
  logic [gne_pkg::REG_IDX_W-1:0]     reg_idx;

  // register file: write completes in the access phase, pready is tied high
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[gne_pkg::PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_cols        <= gne_pkg::RST_GRID_COLS;
      cfg_q.grid_rows        <= gne_pkg::RST_GRID_ROWS;
      cfg_q.allow_diagonal   <= 1'b0;
      cfg_q.ignore_obstacles <= 1'b0;
      cfg_q.cell_pitch       <= gne_pkg::RST_CELL_PITCH;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        gne_pkg::REG_GRID_COLS:        cfg_q.grid_cols <= pwdata[gne_pkg::DIM_W-1:0];
        gne_pkg::REG_GRID_ROWS:        cfg_q.grid_rows <= pwdata[gne_pkg::DIM_W-1:0];
        gne_pkg::REG_ALLOW_DIAGONAL:   cfg_q.allow_diagonal <= pwdata[0];
        gne_pkg::REG_IGNORE_OBSTACLES: cfg_q.ignore_obstacles <= pwdata[0];
        gne_pkg::REG_CELL_PITCH:       cfg_q.cell_pitch <= pwdata[gne_pkg::PITCH_W-1:0];
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gne_pkg::REG_GRID_COLS:        prdata = gne_pkg::APB_DW'(cfg_q.grid_cols);
      gne_pkg::REG_GRID_ROWS:        prdata = gne_pkg::APB_DW'(cfg_q.grid_rows);
      gne_pkg::REG_ALLOW_DIAGONAL:   prdata = gne_pkg::APB_DW'(cfg_q.allow_diagonal);
      gne_pkg::REG_IGNORE_OBSTACLES: prdata = gne_pkg::APB_DW'(cfg_q.ignore_obstacles);
      gne_pkg::REG_CELL_PITCH:       prdata = gne_pkg::APB_DW'(cfg_q.cell_pitch);
      default:                       prdata = '0;
    endcase
  end

  // sequencer: clear sweep, item decode, neighbor scan, edge hand-off
  gne_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // map, divider/root unit, candidate and output registers
  gne_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_func_i          (in_i.func),
    .in_cell_id_i       (in_i.cell_id),
    .in_occupancy_i     (in_i.occupancy),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .out_neighbor_id_o  (out_o.neighbor_id),
    .out_neighbor_col_o (out_o.neighbor_col),
    .out_neighbor_row_o (out_o.neighbor_row),
    .out_edge_cost_o    (out_o.edge_cost),
    .out_last_o         (out_o.last)
  );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Occupancy codes the package does not name
  localparam logic [gne_pkg::OCC_W-1:0] OCC_INTERESTED = 2'd2;
  localparam logic [gne_pkg::OCC_W-1:0] OCC_SPARE      = 2'd3;

  localparam int SETTLE_CYCLES = 120;    // one slow query plus the output register
  localparam int DRAIN_LIMIT   = 50000;
  localparam int HOLD_CYCLES   = 400;    // long receiver back-pressure stretch
  localparam int BURST_ITEMS   = 70;     // six bursts, about 420 random items
  localparam int PRINT_CAP     = 100;

  // One output transfer as seen on the edge channel
  typedef struct {
    logic [gne_pkg::ID_W-1:0]   id;
    logic [gne_pkg::COL_W-1:0]  col;
    logic [gne_pkg::ROW_W-1:0]  row;
    logic [gne_pkg::COST_W-1:0] cost;
    logic                       last;
  } edge_t;

  // Shadow of the configuration and the occupancy map; expands each accepted
  // query into the edges the block must emit, in emit order.
  class edge_scoreboard;
    logic [gne_pkg::OCC_W-1:0]   occ_map [gne_pkg::MAP_DEPTH];
    logic [gne_pkg::DIM_W-1:0]   cols_reg;
    logic [gne_pkg::DIM_W-1:0]   rows_reg;
    logic                        diag_reg;
    logic                        ignore_reg;
    logic [gne_pkg::PITCH_W-1:0] pitch_reg;
    edge_t                       pending_edges [$];
    int                          errors;

    function new();
      foreach (occ_map[i]) occ_map[i] = gne_pkg::OCC_FREE;
      cols_reg   = gne_pkg::RST_GRID_COLS;
      rows_reg   = gne_pkg::RST_GRID_ROWS;
      diag_reg   = 1'b0;
      ignore_reg = 1'b0;
      pitch_reg  = gne_pkg::RST_CELL_PITCH;
      errors     = 0;
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(logic [gne_pkg::REG_IDX_W-1:0] idx,
                          logic [gne_pkg::APB_DW-1:0] val);
      case (idx)
        gne_pkg::REG_GRID_COLS:        cols_reg   = val[gne_pkg::DIM_W-1:0];
        gne_pkg::REG_GRID_ROWS:        rows_reg   = val[gne_pkg::DIM_W-1:0];
        gne_pkg::REG_ALLOW_DIAGONAL:   diag_reg   = val[0];
        gne_pkg::REG_IGNORE_OBSTACLES: ignore_reg = val[0];
        gne_pkg::REG_CELL_PITCH:       pitch_reg  = val[gne_pkg::PITCH_W-1:0];
        default: ;
      endcase
    endfunction

    function int dim_clamp(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    // round(s * sqrt(2)) by integer root of 2*s^2
    function logic [gne_pkg::COST_W-1:0] diagonal_cost(longint unsigned s);
      longint unsigned x, n, t;
      x = 2 * s * s;
      n = 0;
      for (int b = 20; b >= 0; b--) begin
        t = n | (64'd1 << b);
        if (t * t <= x) n = t;
      end
      if (x - n * n > n) n++;
      return n[gne_pkg::COST_W-1:0];
    endfunction

    function void note_item(logic f, logic [gne_pkg::ID_W-1:0] id,
                            logic [gne_pkg::OCC_W-1:0] occ);
      int cols, rows, idv, col, row, nc, nr, nid, ncand, a, b;
      int dc [8];
      int dr [8];
      logic [gne_pkg::COST_W-1:0] straight, diag;
      edge_t e;
      edge_t found [$];
      cols = dim_clamp(int'(cols_reg), gne_pkg::MAX_COLS);
      rows = dim_clamp(int'(rows_reg), gne_pkg::MAX_ROWS);
      idv  = int'(id);
      if (idv >= cols * rows) return;
      if (f == gne_pkg::FUNC_WRITE) begin
        occ_map[idv] = occ;
        return;
      end
      if (!ignore_reg && occ_map[idv] == gne_pkg::OCC_OCCUPIED) return;
      col = idv % cols;
      row = idv / cols;
      ncand = 0;
      if (diag_reg) begin
        // column outer, row inner, center skipped
        for (a = -1; a <= 1; a++) begin
          for (b = -1; b <= 1; b++) begin
            if (a == 0 && b == 0) continue;
            dc[ncand] = a;
            dr[ncand] = b;
            ncand++;
          end
        end
      end else begin
        dc = '{0, 0, 1, -1, 0, 0, 0, 0};
        dr = '{1, -1, 0, 0, 0, 0, 0, 0};
        ncand = 4;
      end
      straight = gne_pkg::COST_W'({pitch_reg, 8'h00});
      diag     = diagonal_cost(longint'(straight));
      for (int i = 0; i < ncand; i++) begin
        nc = col + dc[i];
        nr = row + dr[i];
        if (nc < 0 || nc >= cols || nr < 0 || nr >= rows) continue;
        nid = nr * cols + nc;
        if (!ignore_reg && occ_map[nid] == gne_pkg::OCC_OCCUPIED) continue;
        e.id   = gne_pkg::ID_W'(nid);
        e.col  = gne_pkg::COL_W'(nc);
        e.row  = gne_pkg::ROW_W'(nr);
        e.cost = (dc[i] != 0 && dr[i] != 0) ? diag : straight;
        e.last = 1'b0;
        found.insert(found.size(), e);
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) pending_edges.insert(pending_edges.size(), found[i]);
    endfunction

    task check_edge(edge_t got);
      edge_t want;
      if (pending_edges.size() == 0) begin
        report($sformatf("unexpected edge id %0d col %0d row %0d cost %0d last %0b",
                         got.id, got.col, got.row, got.cost, got.last));
        return;
      end
      want = pending_edges.pop_front();
      if (got.id !== want.id || got.col !== want.col || got.row !== want.row ||
          got.cost !== want.cost || got.last !== want.last)
        report($sformatf("edge id %0d/%0d col %0d/%0d row %0d/%0d cost %0d/%0d last %0b/%0b",
                         got.id, want.id, got.col, want.col, got.row, want.row,
                         got.cost, want.cost, got.last, want.last));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [gne_pkg::PADDR_W-1:0]  paddr;
  logic [gne_pkg::APB_DW-1:0]   pwdata;
  logic [gne_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  gne_in_if  in_bus ();
  gne_out_if out_bus ();

  grid_neighbor_edge_generator dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  edge_scoreboard sb;
  int             src_idle_pct;   // chance per cycle that the sender holds back
  int             snk_idle_pct;   // chance per cycle that the receiver drops ready
  bit             hold_req;       // asks the receiver for a long back-pressure stretch

  // 12 ns clock, low phase first
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Edge receiver: checks each transfer, then picks next cycle's ready.
  // Values are read right after the edge, i.e. as the block saw them.
  initial begin : edge_sink
    int    hold_left;
    edge_t got;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        got.id   = out_bus.neighbor_id;
        got.col  = out_bus.neighbor_col;
        got.row  = out_bus.neighbor_row;
        got.cost = out_bus.edge_cost;
        got.last = out_bus.last;
        sb.check_edge(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // APB write: setup, access; the register takes pwdata at the access edge.
  task automatic write_reg(logic [gne_pkg::REG_IDX_W-1:0] idx,
                           logic [gne_pkg::APB_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_grid(int cols, int rows, bit diag, bit ignore, int pitch);
    write_reg(gne_pkg::REG_GRID_COLS,        gne_pkg::APB_DW'(cols));
    write_reg(gne_pkg::REG_GRID_ROWS,        gne_pkg::APB_DW'(rows));
    write_reg(gne_pkg::REG_ALLOW_DIAGONAL,   gne_pkg::APB_DW'(diag));
    write_reg(gne_pkg::REG_IGNORE_OBSTACLES, gne_pkg::APB_DW'(ignore));
    write_reg(gne_pkg::REG_CELL_PITCH,       gne_pkg::APB_DW'(pitch));
  endtask

  // Offer one item; returns at the edge where the transfer happened.
  // valid stays high into the next item unless the sender idles.
  task automatic send_item(logic f, logic [gne_pkg::ID_W-1:0] id,
                           logic [gne_pkg::OCC_W-1:0] occ);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.func      <= f;
    in_bus.cell_id   <= id;
    in_bus.occupancy <= occ;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_item(f, id, occ);
  endtask

  // Stop sending, wait for every predicted edge, then let a query that
  // yields nothing finish before anything else happens.
  task automatic drain();
    int guard;
    in_bus.valid <= 1'b0;
    guard = 0;
    while (sb.pending_edges.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending_edges.size() != 0) begin
      sb.report($sformatf("%0d expected edges never arrived", sb.pending_edges.size()));
      sb.pending_edges.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly in-range writes and queries on the current grid, some noise
  // with arbitrary ids and codes (out of range on small grids).
  task automatic random_item();
    int cols, rows, area, r;
    logic [gne_pkg::OCC_W-1:0] occ;
    cols = sb.dim_clamp(int'(sb.cols_reg), gne_pkg::MAX_COLS);
    rows = sb.dim_clamp(int'(sb.rows_reg), gne_pkg::MAX_ROWS);
    area = cols * rows;
    r = $urandom_range(99);
    if (r < 8) begin
      send_item(1'($urandom_range(1)), gne_pkg::ID_W'($urandom_range(4095)),
                gne_pkg::OCC_W'($urandom_range(3)));
    end else if (r < 45) begin
      occ = $urandom_range(1) ? gne_pkg::OCC_OCCUPIED : gne_pkg::OCC_W'($urandom_range(3));
      send_item(gne_pkg::FUNC_WRITE, gne_pkg::ID_W'($urandom_range(area - 1)), occ);
    end else begin
      send_item(gne_pkg::FUNC_QUERY, gne_pkg::ID_W'($urandom_range(area - 1)),
                gne_pkg::OCC_W'($urandom_range(3)));
    end
  endtask

  task automatic random_burst(int n, int hold_at, int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1'b1;   // sender keeps offering meanwhile
      if (i == pause_at) drain();
      random_item();
    end
  endtask

  initial begin : stimulus
    sb = new();
    hold_req     = 1'b0;
    src_idle_pct = 18;
    snk_idle_pct = 46;
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.func      <= gne_pkg::FUNC_WRITE;
    in_bus.cell_id   <= '0;
    in_bus.occupancy <= gne_pkg::OCC_FREE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: 64x64, four-connected, obstacles honored, pitch 10.
    // in_i.ready stays low through the map clear, send_item waits it out.
    send_item(gne_pkg::FUNC_QUERY, 12'd0,    gne_pkg::OCC_FREE);      // corner
    send_item(gne_pkg::FUNC_QUERY, 12'd4095, gne_pkg::OCC_FREE);      // far corner
    send_item(gne_pkg::FUNC_QUERY, 12'd2080, gne_pkg::OCC_FREE);      // interior
    send_item(gne_pkg::FUNC_WRITE, 12'd65,   gne_pkg::OCC_OCCUPIED);
    send_item(gne_pkg::FUNC_QUERY, 12'd64,   gne_pkg::OCC_FREE);      // occupied neighbor skipped
    send_item(gne_pkg::FUNC_QUERY, 12'd65,   gne_pkg::OCC_FREE);      // occupied source, nothing
    send_item(gne_pkg::FUNC_WRITE, 12'd65,   OCC_SPARE);              // code three is not occupied
    send_item(gne_pkg::FUNC_QUERY, 12'd65,   gne_pkg::OCC_FREE);
    send_item(gne_pkg::FUNC_WRITE, 12'd4095, OCC_INTERESTED);
    send_item(gne_pkg::FUNC_QUERY, 12'd4094, gne_pkg::OCC_FREE);
    drain();

    // Single cell: no neighbors, and ids past the grid
    set_grid(1, 1, 1'b0, 1'b0, 1);
    send_item(gne_pkg::FUNC_QUERY, 12'd0,    gne_pkg::OCC_FREE);
    send_item(gne_pkg::FUNC_QUERY, 12'd1,    gne_pkg::OCC_FREE);
    send_item(gne_pkg::FUNC_WRITE, 12'd4095, gne_pkg::OCC_OCCUPIED);
    drain();

    // Zero columns and oversize rows saturate; zero pitch; obstacles ignored
    set_grid(0, 127, 1'b1, 1'b1, 0);
    send_item(gne_pkg::FUNC_QUERY, 12'd5, gne_pkg::OCC_FREE);
    send_item(gne_pkg::FUNC_WRITE, 12'd6, gne_pkg::OCC_OCCUPIED);
    send_item(gne_pkg::FUNC_QUERY, 12'd6, gne_pkg::OCC_FREE);
    drain();

    // One row of 64; map is reinterpreted, not cleared; widest pitch
    set_grid(127, 0, 1'b1, 1'b0, 1023);
    send_item(gne_pkg::FUNC_QUERY, 12'd0,  gne_pkg::OCC_FREE);
    send_item(gne_pkg::FUNC_QUERY, 12'd63, gne_pkg::OCC_FREE);
    send_item(gne_pkg::FUNC_QUERY, 12'd6,  gne_pkg::OCC_FREE);
    send_item(gne_pkg::FUNC_QUERY, 12'd5,  gne_pkg::OCC_FREE);
    drain();

    // 3x3 with all eight neighbors around the center
    set_grid(3, 3, 1'b1, 1'b0, 1);
    send_item(gne_pkg::FUNC_QUERY, 12'd4, gne_pkg::OCC_FREE);
    send_item(gne_pkg::FUNC_WRITE, 12'd6, gne_pkg::OCC_FREE);
    send_item(gne_pkg::FUNC_QUERY, 12'd4, gne_pkg::OCC_FREE);
    send_item(gne_pkg::FUNC_QUERY, 12'd8, gne_pkg::OCC_FREE);
    drain();

    // Random bursts: two per idling pattern, small grids mostly
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin src_idle_pct = 18; snk_idle_pct = 46; end
        1: begin src_idle_pct = 46; snk_idle_pct = 18; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      case (seg)
        0: set_grid(5, 4, 1'b1, 1'b0, 1023);
        1: set_grid(8, 8, 1'b0, 1'b0, $urandom_range(1023));
        2: set_grid(3, 7, 1'b1, 1'b1, 1);
        3: set_grid(64, 64, 1'b1, 1'b0, $urandom_range(1023));
        4: set_grid($urandom_range(1, 10), $urandom_range(1, 10), 1'($urandom_range(1)),
                    1'($urandom_range(1)), $urandom_range(1023));
        default: set_grid(6, 5, 1'b1, 1'b0, 10);
      endcase
      case (seg)
        0: random_burst(BURST_ITEMS, 20, -1);   // long back-pressure
        1: random_burst(BURST_ITEMS, -1, 35);   // sender waits for all edges
        4: random_burst(BURST_ITEMS, 30, -1);
        default: random_burst(BURST_ITEMS, -1, -1);
      endcase
      drain();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
